// ===== design/isv_pkg.sv =====
package isv_pkg;

  localparam logic [3:0] IsbnLen      = 4'd13;
  localparam logic [3:0] IssnLen      = 4'd9;
  localparam logic [2:0] IsbnDashes   = 3'd3;
  localparam logic [2:0] IssnDashes   = 3'd1;
  localparam logic [3:0] CountMax     = 4'd15;
  localparam logic [3:0] XValue       = 4'd10;
  localparam logic [3:0] IssnTopWt    = 4'd8;
  localparam logic [3:0] SyntaxRem    = 4'd12;
  localparam logic [7:0] Modulus      = 8'd11;
  // floor(x * 187 / 2048) equals floor(x / 11) for every x below 230, which covers
  // the largest weighted term of 140.
  localparam logic [7:0] RecipMod11   = 8'd187;
  localparam int unsigned RecipShift  = 11;

  localparam logic [7:0] CharDash  = 8'h2D;
  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] CharNine  = 8'h39;
  localparam logic [7:0] CharUpX   = 8'h58;
  localparam logic [7:0] CharLowX  = 8'h78;

  typedef enum logic {
    KIND_ISBN = 1'b0,
    KIND_ISSN = 1'b1
  } id_kind_e;

  typedef enum logic [1:0] {
    ST_VALID    = 2'd0,
    ST_LENGTH   = 2'd1,
    ST_SYNTAX   = 2'd2,
    ST_CHECKSUM = 2'd3
  } status_e;

  typedef struct packed {
    logic       is_dash;
    logic       is_value;
    logic [3:0] value;
  } char_class_t;

  function automatic logic [3:0] mod11(input logic [7:0] x);
    logic [15:0] prod;
    logic [3:0]  q;
    logic [7:0]  qm;
    prod = 16'(x) * 16'(RecipMod11);
    q    = prod[RecipShift +: 4];
    qm   = 8'(q) * Modulus;
    return 4'(x - qm);
  endfunction

endpackage

// ===== design/isbn_issn_mod11_validator_top.sv =====
// ISBN / ISSN mod 11 check-digit validator.
//
// Input channel: one character per request on char_code_i, with last_char_i
// set on the final character of a string (in_valid_i / in_ready_o).
// Output channel: one request per string on status_o and remainder_o, given
// after its last character (out_valid_o / out_ready_i).
// Configuration: cfg_we_i writes cfg_wdata_i into the mode register,
// 0 for ISBN and 1 for ISSN; write it only while no string is in flight.
//
// Each character passes an input register, then combinational decode,
// weighting and mod 11 reduction into the string state and result register.
// out_valid_o is set when the last character leaves the input register.
// Throughput is one character per cycle unless a last character is stalled. A result waiting on out_ready_i
// stalls only a pending last character; other characters keep flowing.
// Reset clears the mode to ISBN, empties both registers and clears the
// string state.
module isbn_issn_mod11_validator_top
  import isv_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_wdata_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] char_code_i,
  input  logic       last_char_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [1:0] status_o,
  output logic [3:0] remainder_o
);

  id_kind_e    kind_q;
  logic        in_valid_q;
  logic [7:0]  char_q;
  logic        last_q;
  logic        res_valid_q;
  status_e     res_status_q;
  logic [3:0]  res_rem_q;

  char_class_t cls;
  status_e     status_next;
  logic [3:0]  rem_next;
  logic        res_free;
  logic        advance;

  assign res_free   = !res_valid_q || out_ready_i;
  assign advance    = in_valid_q && (!last_q || res_free);
  assign in_ready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kind_q <= KIND_ISBN;
    end else if (cfg_we_i) begin
      kind_q <= id_kind_e'(cfg_wdata_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      char_q <= char_code_i;
      last_q <= last_char_i;
    end
  end

  isv_char_decode u_decode (
    .char_code_i (char_q),
    .cls_o       (cls)
  );

  isv_accum u_accum (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .kind_i      (kind_q),
    .step_i      (advance),
    .last_i      (last_q),
    .cls_i       (cls),
    .status_o    (status_next),
    .remainder_o (rem_next)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (res_free) begin
      res_valid_q <= advance && last_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && last_q) begin
      res_status_q <= status_next;
      res_rem_q    <= rem_next;
    end
  end

  assign out_valid_o = res_valid_q;
  assign status_o    = res_status_q;
  assign remainder_o = res_rem_q;

endmodule

// ===== design/isv_char_decode.sv =====
module isv_char_decode
  import isv_pkg::*;
(
  input  logic [7:0]  char_code_i,
  output char_class_t cls_o
);

  always_comb begin
    cls_o          = '0;
    cls_o.is_dash  = (char_code_i == CharDash);
    if (char_code_i >= CharZero && char_code_i <= CharNine) begin
      cls_o.is_value = 1'b1;
      cls_o.value    = 4'(char_code_i - CharZero);
    end else if (char_code_i == CharUpX || char_code_i == CharLowX) begin
      cls_o.is_value = 1'b1;
      cls_o.value    = XValue;
    end
  end

endmodule

// ===== design/isv_accum.sv =====
module isv_accum
  import isv_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  id_kind_e    kind_i,
  input  logic        step_i,
  input  logic        last_i,
  input  char_class_t cls_i,
  output status_e     status_o,
  output logic [3:0]  remainder_o
);

  logic [3:0] char_count_q, char_count_d;
  logic [2:0] dash_count_q, dash_count_d;
  logic [3:0] running_sum_q, running_sum_d;
  logic       syntax_error_q, syntax_error_d;

  logic [3:0] req_len;
  logic [2:0] max_dashes;
  logic [3:0] count_inc;
  logic       checked;
  logic [3:0] rel_pos;
  logic [3:0] weight;
  logic [7:0] term;

  assign req_len    = (kind_i == KIND_ISSN) ? IssnLen : IsbnLen;
  assign max_dashes = (kind_i == KIND_ISSN) ? IssnDashes : IsbnDashes;
  assign count_inc  = (char_count_q == CountMax) ? CountMax : char_count_q + 4'd1;
  assign checked    = !syntax_error_q && (char_count_q < req_len);

  // Position among non-dash characters; dashes never outnumber earlier positions.
  assign rel_pos = char_count_q - 4'(dash_count_q);
  assign weight  = (kind_i == KIND_ISSN) ? IssnTopWt - rel_pos : rel_pos + 4'd1;
  assign term    = 8'(running_sum_q) + 8'(cls_i.value) * 8'(weight);

  always_comb begin
    char_count_d   = count_inc;
    dash_count_d   = dash_count_q;
    running_sum_d  = running_sum_q;
    syntax_error_d = syntax_error_q;
    if (checked) begin
      if (cls_i.is_dash) begin
        if (dash_count_q >= max_dashes) begin
          syntax_error_d = 1'b1;
        end else begin
          dash_count_d = dash_count_q + 3'd1;
        end
      end else if (cls_i.is_value) begin
        running_sum_d = mod11(term);
      end else begin
        syntax_error_d = 1'b1;
      end
    end

    if (count_inc != req_len) begin
      status_o    = ST_LENGTH;
      remainder_o = 4'd0;
    end else if (syntax_error_d) begin
      status_o    = ST_SYNTAX;
      remainder_o = SyntaxRem;
    end else if (running_sum_d != 4'd0) begin
      status_o    = ST_CHECKSUM;
      remainder_o = running_sum_d;
    end else begin
      status_o    = ST_VALID;
      remainder_o = 4'd0;
    end

    // The last character closes the string; the next one starts fresh.
    if (last_i) begin
      char_count_d   = '0;
      dash_count_d   = '0;
      running_sum_d  = '0;
      syntax_error_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      char_count_q   <= '0;
      dash_count_q   <= '0;
      running_sum_q  <= '0;
      syntax_error_q <= 1'b0;
    end else if (step_i) begin
      char_count_q   <= char_count_d;
      dash_count_q   <= dash_count_d;
      running_sum_q  <= running_sum_d;
      syntax_error_q <= syntax_error_d;
    end
  end

  a_sum_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    running_sum_q < 4'(Modulus))
    else $error("running sum left the mod 11 range");

  a_dash_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dash_count_q <= IsbnDashes)
    else $error("dash count exceeds the largest allowed count");

  a_clear_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && last_i |=> char_count_q == 4'd0 && !syntax_error_q && running_sum_q == 4'd0)
    else $error("string state not cleared after the last character");

  a_dashes_behind_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    4'(dash_count_q) <= char_count_q)
    else $error("more dashes than characters");

endmodule
